/* design/bprc_pkg.sv */
// Shared constants, types and helpers for the bit pattern row/column counter.
package bprc_pkg;

    localparam int MAX_COLUMNS  = 64;
    localparam int COL_W        = $clog2(MAX_COLUMNS);
    localparam int PATTERN_BITS = 16;
    localparam int COUNT_W      = 16;
    localparam int WIDTH_W      = 7;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_VALUE = 1'b0,
        REG_ROW_WIDTH     = 1'b1
    } cfg_reg_t;

    // Cell held in the match stage, with the column state sampled at transfer.
    typedef struct packed {
        logic [COL_W-1:0]        col;
        logic                    cell_bit;
        logic                    last_cell;
        logic                    col_valid;
        logic                    byp_hit;
        logic [PATTERN_BITS-1:0] byp_data;
    } stage_t;

    // Column window write from the match stage.
    typedef struct packed {
        logic                    en;
        logic [COL_W-1:0]        addr;
        logic [PATTERN_BITS-1:0] data;
    } col_wr_t;

    // Bit i is set when the pattern has a set bit at position i or above.
    function automatic logic [PATTERN_BITS-1:0] pattern_mask(
        input logic [PATTERN_BITS-1:0] pat
    );
        logic [PATTERN_BITS-1:0] m;
        begin
            for (int i = 0; i < PATTERN_BITS; i++)
            begin
                m[i] = |(pat >> i);
            end
            return m;
        end
    endfunction

endpackage

/* design/bprc_if.sv */
// Valid/ready channels for matrix cells and match totals.
interface bprc_cell_if;
    import bprc_pkg::*;
    logic valid;
    logic ready;
    logic cell_bit;
    logic last_cell;

    modport source (output valid, output cell_bit, output last_cell, input ready);
    modport sink   (input valid, input cell_bit, input last_cell, output ready);
endinterface

interface bprc_total_if;
    import bprc_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;

    modport source (output valid, output match_count, input ready);
    modport sink   (input valid, input match_count, output ready);
endinterface

/* design/bprc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bprc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/bprc_front.sv */
// Input stage: column position, column valid bits, store read and stage register.
module bprc_front
    import bprc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    bprc_cell_if.sink           cells,
    input  logic [WIDTH_W-1:0]  row_width,
    input  logic                go,
    input  col_wr_t             col_wr,
    output logic                stage_valid,
    output stage_t              stage,
    output logic                rd_en,
    output logic [COL_W-1:0]    rd_addr
);

    logic [COL_W-1:0]       col_pos_reg, col_pos_next;
    logic [MAX_COLUMNS-1:0] col_valid_reg, col_valid_next;
    logic                   stage_valid_reg, stage_valid_next;
    stage_t                 stage_reg, stage_next;
    logic [WIDTH_W-1:0]     eff_width;
    logic [WIDTH_W-1:0]     col_plus;
    logic                   accept;

    assign cells.ready = !stage_valid_reg || go;
    assign accept      = cells.valid && cells.ready;

    // Width zero acts as one column, widths past the store saturate.
    always_comb
    begin
        if (row_width == '0)
        begin
            eff_width = WIDTH_W'(1);
        end
        else if (row_width > WIDTH_W'(MAX_COLUMNS))
        begin
            eff_width = WIDTH_W'(MAX_COLUMNS);
        end
        else
        begin
            eff_width = row_width;
        end
    end

    assign col_plus = WIDTH_W'(col_pos_reg) + WIDTH_W'(1);

    always_comb
    begin
        col_pos_next     = col_pos_reg;
        col_valid_next   = col_valid_reg;
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (accept)
        begin
            stage_valid_next     = 1'b1;
            stage_next.col       = col_pos_reg;
            stage_next.cell_bit  = cells.cell_bit;
            stage_next.last_cell = cells.last_cell;
            stage_next.col_valid = col_valid_reg[col_pos_reg];
            // Catch the window written back in this same cycle.
            stage_next.byp_hit   = col_wr.en && (col_wr.addr == col_pos_reg);
            stage_next.byp_data  = col_wr.data;
            if (cells.last_cell)
            begin
                col_pos_next   = '0;
                col_valid_next = '0;
            end
            else
            begin
                col_pos_next   = (col_plus >= eff_width) ? '0 : col_plus[COL_W-1:0];
                col_valid_next = col_valid_reg | (MAX_COLUMNS'(1) << col_pos_reg);
            end
        end
        else if (go)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg     <= '0;
            col_valid_reg   <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            col_pos_reg     <= col_pos_next;
            col_valid_reg   <= col_valid_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;
    assign rd_en       = accept;
    assign rd_addr     = col_pos_reg;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cells.last_cell |=> col_pos_reg == '0 && col_valid_reg == '0)
        else $error("matrix end did not clear column state");

endmodule

/* design/bprc_match.sv */
// Match stage: window update, pattern compare, saturating count and result register.
module bprc_match
    import bprc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    stage_valid,
    input  stage_t                  stage,
    input  logic [PATTERN_BITS-1:0] rd_data,
    input  logic [PATTERN_BITS-1:0] pattern,
    output logic                    go,
    output col_wr_t                 col_wr,
    bprc_total_if.source            totals
);

    logic [PATTERN_BITS-1:0] row_window_reg, row_window_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;
    logic [PATTERN_BITS-1:0] mask;
    logic [PATTERN_BITS-1:0] cw_old, cw_new, rw_base, rw_new;
    logic                    row_hit, col_hit, fire;
    logic [COUNT_W:0]        sum;
    logic [COUNT_W-1:0]      count_sat;

    // Hold only a final cell whose total cannot yet enter the result register.
    assign go   = !(stage.last_cell && out_valid_reg && !totals.ready);
    assign fire = stage_valid && go;

    assign mask = pattern_mask(pattern);

    always_comb
    begin
        if (!stage.col_valid)
        begin
            cw_old = '0;
        end
        else if (stage.byp_hit)
        begin
            cw_old = stage.byp_data;
        end
        else
        begin
            cw_old = rd_data;
        end
    end

    assign cw_new  = {cw_old[PATTERN_BITS-2:0], stage.cell_bit};
    assign rw_base = (stage.col == '0) ? '0 : row_window_reg;
    assign rw_new  = {rw_base[PATTERN_BITS-2:0], stage.cell_bit};

    assign row_hit = (pattern != '0) && ((rw_new & mask) == pattern);
    assign col_hit = (pattern != '0) && ((cw_new & mask) == pattern);

    assign sum       = {1'b0, count_reg} + (COUNT_W+1)'(row_hit) + (COUNT_W+1)'(col_hit);
    assign count_sat = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

    always_comb
    begin
        row_window_next = row_window_reg;
        count_next      = count_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !totals.ready;
        if (fire)
        begin
            if (stage.last_cell)
            begin
                row_window_next = '0;
                count_next      = '0;
                out_count_next  = count_sat;
                out_valid_next  = 1'b1;
            end
            else
            begin
                row_window_next = rw_new;
                count_next      = count_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_window_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            row_window_reg <= row_window_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
    end

    assign col_wr.en          = fire;
    assign col_wr.addr        = stage.col;
    assign col_wr.data        = cw_new;
    assign totals.valid       = out_valid_reg;
    assign totals.match_count = out_count_reg;

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage.last_cell |=> out_valid_reg)
        else $error("final cell produced no total");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage.last_cell |=> count_reg == '0 && row_window_reg == '0)
        else $error("count not cleared after matrix end");

endmodule

/* design/bit_pattern_row_column_counter.sv */
// A final cell's total passes the stage register and then the result register before it is valid.
// Throughput: one cell per cycle; the column store does one read and one write a cycle.
// The input stalls only while a total waits in the result register and the next final
// cell is ready to replace it.
// Reset clears position, valid bits, row window, count and result valid; pattern resets to 1,
// row width to 64. The column store is not cleared: its valid bits gate every read.
module bit_pattern_row_column_counter
    import bprc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    bprc_cell_if.sink             cells,
    bprc_total_if.source          totals
);

    logic [PATTERN_BITS-1:0] pattern_reg;
    logic [WIDTH_W-1:0]      row_width_reg;
    logic                    go;
    logic                    stage_valid;
    stage_t                  stage;
    col_wr_t                 col_wr;
    logic                    rd_en;
    logic [COL_W-1:0]        rd_addr;
    logic [PATTERN_BITS-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= PATTERN_BITS'(1);
            row_width_reg <= WIDTH_W'(MAX_COLUMNS);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_PATTERN_VALUE: pattern_reg   <= cfg_wdata[PATTERN_BITS-1:0];
                REG_ROW_WIDTH:     row_width_reg <= cfg_wdata[WIDTH_W-1:0];
                default:           pattern_reg   <= pattern_reg;
            endcase
        end
    end

    bprc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cells       (cells),
        .row_width   (row_width_reg),
        .go          (go),
        .col_wr      (col_wr),
        .stage_valid (stage_valid),
        .stage       (stage),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    bprc_ram #(
        .WIDTH (PATTERN_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_col_store (
        .clk     (clk),
        .wr_en   (col_wr.en),
        .wr_addr (col_wr.addr),
        .wr_data (col_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bprc_match u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .rd_data     (rd_data),
        .pattern     (pattern_reg),
        .go          (go),
        .col_wr      (col_wr),
        .totals      (totals)
    );

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cells.ready |-> totals.valid && !totals.ready && stage_valid && stage.last_cell)
        else $error("input stalled without a blocked total");

endmodule
